### rtl/core/rrts_pkg.sv
`default_nettype none
package rrts_pkg;

	localparam int SLICE_BITS = 8;
	localparam int TICK_BITS  = 32;
	localparam int CMD_BITS   = 3;
	localparam int STAT_BITS  = 2;

	localparam logic [SLICE_BITS-1:0] SLICE_RESET = 8'd5;

	// command codes
	localparam logic [CMD_BITS-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_YIELD  = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_CREATE = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_BLOCK  = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_WAKE   = 3'd4;
	localparam logic [CMD_BITS-1:0] CMD_EXIT   = 3'd5;

	// result status codes
	localparam logic [STAT_BITS-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_BITS-1:0] STAT_REFUSED = 2'd1;
	localparam logic [STAT_BITS-1:0] STAT_NO_FREE = 2'd2;
	localparam logic [STAT_BITS-1:0] STAT_NULL    = 2'd3;

	// slot states
	localparam logic [1:0] SS_FREE  = 2'd0;
	localparam logic [1:0] SS_READY = 2'd1;
	localparam logic [1:0] SS_RUN   = 2'd2;
	localparam logic [1:0] SS_BLOCK = 2'd3;

	// configuration register indexes
	localparam logic REG_PREEMPT = 1'b0;
	localparam logic REG_SLICE   = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FIND, S_APPLY1, S_APPLY2, S_APPLY3,
		S_FREE_SCAN, S_CREATE1, S_CREATE2, S_EX_SEARCH, S_EX_FIX,
		S_EX_LINK, S_FINISH, S_OUT
	} fsm_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_DECODE, OP_FIND, OP_APPLY1, OP_APPLY2,
		OP_APPLY3, OP_FREE_SCAN, OP_CREATE1, OP_CREATE2, OP_EX_SEARCH,
		OP_EX_FIX, OP_EX_LINK
	} op_t;

	typedef enum logic [1:0] {
		R_FINISH, R_FIND, R_CREATE, R_EXIT
	} route_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		route_t route;
		logic   hit;
		logic   last;
		logic   found;
		logic   is_block;
	} dp_stat_t;

	typedef struct packed {
		logic                  we;
		logic                  sel;
		logic [SLICE_BITS-1:0] data;
	} cfg_wr_t;

endpackage
`default_nettype wire

### rtl/core/rrts_ram.sv
`default_nettype none
module rrts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/rrts_ctrl.sv
`default_nettype none
module rrts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire rrts_pkg::dp_stat_t stat,
	output rrts_pkg::dp_cmd_t      cmd,
	output logic                   busy,
	output logic                   done
);

	rrts_pkg::fsm_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrts_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.op    = rrts_pkg::OP_NONE;
		case (state_q)
			rrts_pkg::S_IDLE: begin
				if (start) begin
					cmd.op    = rrts_pkg::OP_LOAD;
					state_nxt = rrts_pkg::S_DECODE;
				end
			end
			rrts_pkg::S_DECODE: begin
				cmd.op = rrts_pkg::OP_DECODE;
				case (stat.route)
					rrts_pkg::R_FIND:   state_nxt = rrts_pkg::S_FIND;
					rrts_pkg::R_CREATE: state_nxt = rrts_pkg::S_FREE_SCAN;
					rrts_pkg::R_EXIT:   state_nxt = rrts_pkg::S_EX_SEARCH;
					default:            state_nxt = rrts_pkg::S_FINISH;
				endcase
			end
			rrts_pkg::S_FIND: begin
				cmd.op = rrts_pkg::OP_FIND;
				if (stat.hit) begin
					state_nxt = rrts_pkg::S_APPLY1;
				end else if (stat.last) begin
					// a block with nobody else ready is refused untouched
					state_nxt = stat.is_block ? rrts_pkg::S_FINISH : rrts_pkg::S_APPLY1;
				end
			end
			rrts_pkg::S_APPLY1: begin
				cmd.op    = rrts_pkg::OP_APPLY1;
				state_nxt = stat.found ? rrts_pkg::S_APPLY2 : rrts_pkg::S_FINISH;
			end
			rrts_pkg::S_APPLY2: begin
				cmd.op    = rrts_pkg::OP_APPLY2;
				state_nxt = rrts_pkg::S_APPLY3;
			end
			rrts_pkg::S_APPLY3: begin
				cmd.op    = rrts_pkg::OP_APPLY3;
				state_nxt = rrts_pkg::S_FINISH;
			end
			rrts_pkg::S_FREE_SCAN: begin
				cmd.op = rrts_pkg::OP_FREE_SCAN;
				if (stat.hit) begin
					state_nxt = rrts_pkg::S_CREATE1;
				end else if (stat.last) begin
					state_nxt = rrts_pkg::S_FINISH;
				end
			end
			rrts_pkg::S_CREATE1: begin
				cmd.op    = rrts_pkg::OP_CREATE1;
				state_nxt = rrts_pkg::S_CREATE2;
			end
			rrts_pkg::S_CREATE2: begin
				cmd.op    = rrts_pkg::OP_CREATE2;
				state_nxt = rrts_pkg::S_FINISH;
			end
			rrts_pkg::S_EX_SEARCH: begin
				cmd.op = rrts_pkg::OP_EX_SEARCH;
				if (stat.hit || stat.last) begin
					state_nxt = rrts_pkg::S_EX_FIX;
				end
			end
			rrts_pkg::S_EX_FIX: begin
				cmd.op    = rrts_pkg::OP_EX_FIX;
				state_nxt = stat.found ? rrts_pkg::S_EX_LINK : rrts_pkg::S_FIND;
			end
			rrts_pkg::S_EX_LINK: begin
				cmd.op    = rrts_pkg::OP_EX_LINK;
				state_nxt = rrts_pkg::S_FIND;
			end
			rrts_pkg::S_FINISH: begin
				state_nxt = rrts_pkg::S_OUT;
			end
			rrts_pkg::S_OUT: begin
				state_nxt = rrts_pkg::S_IDLE;
			end
			default: begin
				state_nxt = rrts_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != rrts_pkg::S_IDLE);
	assign done = (state_q == rrts_pkg::S_OUT);

endmodule
`default_nettype wire

### rtl/core/rrts_dp.sv
`default_nettype none
module rrts_dp #(
	parameter int MAX_THREADS  = 16,
	parameter int CONTEXT_BITS = 48,
	parameter int ID_BITS      = 32,
	localparam int SW          = $clog2(MAX_THREADS)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire rrts_pkg::dp_cmd_t               cmd,
	output rrts_pkg::dp_stat_t                   stat,
	input  wire rrts_pkg::cfg_wr_t               cfg,
	input  wire logic [rrts_pkg::CMD_BITS-1:0]   cmd_in,
	input  wire logic [CONTEXT_BITS-1:0]         ptr_in,
	input  wire logic [SW-1:0]                   tgt_in,
	output logic      [rrts_pkg::STAT_BITS-1:0]  status,
	output logic                                 switched,
	output logic      [SW-1:0]                   current_slot,
	output logic      [ID_BITS-1:0]              current_id,
	output logic      [CONTEXT_BITS-1:0]         resume_ptr,
	output logic      [SW-1:0]                   new_slot,
	output logic      [ID_BITS-1:0]              new_id,
	output logic      [SW-1:0]                   live_count,
	output logic      [rrts_pkg::TICK_BITS-1:0]  tick_count,
	output logic                                 fault,
	output logic                                 preempt_q,
	output logic      [rrts_pkg::SLICE_BITS-1:0] slice_len_q
);

	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_THREADS - 1);

	logic [1:0]    slot_state_q [MAX_THREADS];
	logic [SW-1:0] slot_link_q  [MAX_THREADS];

	logic [rrts_pkg::CMD_BITS-1:0]   cmd_q;
	logic [CONTEXT_BITS-1:0]         ptr_q, resume_q;
	logic [SW-1:0]                   tgt_q, run_q, head_q, tail_q, live_q;
	logic [SW-1:0]                   c_q, start_q, i_q, cand_q, nx_q, ns_q;
	logic [ID_BITS-1:0]              next_id_q, nid_q;
	logic [rrts_pkg::STAT_BITS-1:0]  status_q;
	logic                            sw_q, found_q, fault_q;
	logic [rrts_pkg::TICK_BITS-1:0]  ticks_q;
	logic [rrts_pkg::SLICE_BITS-1:0] slice_q, slice_inc;

	logic                           tgt_ok, is_block;
	logic [SW-1:0]                  rd_a;
	logic [1:0]                     rd_st;
	logic [SW-1:0]                  rd_lk;
	rrts_pkg::route_t               route;
	logic [rrts_pkg::STAT_BITS-1:0] dec_stat;

	logic          st_we, lk_we, ctx_we, id_we;
	logic [SW-1:0] st_wa, lk_wa, ctx_wa;
	logic [1:0]    st_wd;
	logic [SW-1:0] lk_wd;
	logic [CONTEXT_BITS-1:0] ctx_wd, ctx_rdata;
	logic [ID_BITS-1:0]      id_rdata;

	assign tgt_ok    = ({1'b0, tgt_q} < (SW + 1)'(MAX_THREADS));
	assign is_block  = (cmd_q == rrts_pkg::CMD_BLOCK);
	assign slice_inc = slice_q + 1'b1;

	always_comb begin
		case (cmd.op)
			rrts_pkg::OP_DECODE:
				rd_a = (cmd_q == rrts_pkg::CMD_WAKE) ? (tgt_ok ? tgt_q : '0) : run_q;
			rrts_pkg::OP_FIND, rrts_pkg::OP_EX_SEARCH: rd_a = c_q;
			rrts_pkg::OP_FREE_SCAN:                    rd_a = i_q;
			default:                                   rd_a = run_q;
		endcase
	end

	assign rd_st = slot_state_q[rd_a];
	assign rd_lk = slot_link_q[rd_a];

	// decode the captured word
	always_comb begin
		route    = rrts_pkg::R_FINISH;
		dec_stat = rrts_pkg::STAT_OK;
		if (cmd_q == rrts_pkg::CMD_WAKE) begin
			if (!(tgt_ok && rd_st == rrts_pkg::SS_BLOCK)) begin
				dec_stat = rrts_pkg::STAT_REFUSED;
			end
		end else if (cmd_q > rrts_pkg::CMD_EXIT) begin
			dec_stat = rrts_pkg::STAT_REFUSED;
		end else if (ptr_q == '0) begin
			dec_stat = rrts_pkg::STAT_NULL;
		end else begin
			case (cmd_q)
				rrts_pkg::CMD_TICK: begin
					if (preempt_q && slice_inc >= slice_len_q) begin
						route = rrts_pkg::R_FIND;
					end
				end
				rrts_pkg::CMD_YIELD:  route = rrts_pkg::R_FIND;
				rrts_pkg::CMD_CREATE: route = rrts_pkg::R_CREATE;
				rrts_pkg::CMD_BLOCK: begin
					if (run_q == '0 || rd_st != rrts_pkg::SS_RUN) begin
						dec_stat = rrts_pkg::STAT_REFUSED;
					end else begin
						route = rrts_pkg::R_FIND;
					end
				end
				rrts_pkg::CMD_EXIT: begin
					if (run_q == '0) begin
						dec_stat = rrts_pkg::STAT_REFUSED;
					end else begin
						route = rrts_pkg::R_EXIT;
					end
				end
				default: dec_stat = rrts_pkg::STAT_REFUSED;
			endcase
		end
	end

	always_comb begin
		stat.route    = route;
		stat.found    = found_q;
		stat.is_block = is_block;
		stat.hit      = 1'b0;
		stat.last     = 1'b0;
		case (cmd.op)
			rrts_pkg::OP_FIND: begin
				stat.hit  = (rd_st == rrts_pkg::SS_READY);
				stat.last = !stat.hit && (rd_lk == start_q || i_q == LAST_SLOT);
			end
			rrts_pkg::OP_FREE_SCAN: begin
				stat.hit  = (rd_st == rrts_pkg::SS_FREE);
				stat.last = !stat.hit && (i_q == LAST_SLOT);
			end
			rrts_pkg::OP_EX_SEARCH: begin
				stat.hit  = (rd_lk == run_q);
				stat.last = !stat.hit && (i_q == LAST_SLOT);
			end
			default: begin
				stat.hit  = 1'b0;
				stat.last = 1'b0;
			end
		endcase
	end

	// table writes, one state and one link entry a cycle
	always_comb begin
		st_we  = 1'b0;
		st_wa  = run_q;
		st_wd  = rrts_pkg::SS_READY;
		lk_we  = 1'b0;
		lk_wa  = tail_q;
		lk_wd  = head_q;
		ctx_we = 1'b0;
		ctx_wa = run_q;
		ctx_wd = ptr_q;
		id_we  = 1'b0;
		case (cmd.op)
			rrts_pkg::OP_DECODE: begin
				if (cmd_q == rrts_pkg::CMD_WAKE && dec_stat == rrts_pkg::STAT_OK) begin
					st_we = 1'b1;
					st_wa = rd_a;
				end
			end
			rrts_pkg::OP_APPLY1: begin
				ctx_we = 1'b1;
				if (found_q) begin
					if (is_block) begin
						st_we = 1'b1;
						st_wd = rrts_pkg::SS_BLOCK;
					end else if (rd_st == rrts_pkg::SS_RUN) begin
						st_we = 1'b1;
					end
				end
			end
			rrts_pkg::OP_APPLY2: begin
				st_we = 1'b1;
				st_wa = cand_q;
				st_wd = rrts_pkg::SS_RUN;
			end
			rrts_pkg::OP_CREATE1: begin
				st_we  = 1'b1;
				st_wa  = cand_q;
				lk_we  = 1'b1;
				lk_wa  = cand_q;
				ctx_we = 1'b1;
				ctx_wa = cand_q;
				id_we  = 1'b1;
			end
			rrts_pkg::OP_CREATE2: begin
				lk_we = 1'b1;
				lk_wd = cand_q;
			end
			rrts_pkg::OP_EX_FIX: begin
				st_we = 1'b1;
				st_wd = rrts_pkg::SS_FREE;
				if (found_q) begin
					lk_we = 1'b1;
					lk_wa = c_q;
					lk_wd = nx_q;
				end
			end
			rrts_pkg::OP_EX_LINK: begin
				lk_we = 1'b1;
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_THREADS; k++) begin
				slot_state_q[k] <= rrts_pkg::SS_FREE;
				slot_link_q[k]  <= '0;
			end
			slot_state_q[0] <= rrts_pkg::SS_RUN;
		end else begin
			if (st_we) begin
				slot_state_q[st_wa] <= st_wd;
			end
			if (lk_we) begin
				slot_link_q[lk_wa] <= lk_wd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= rrts_pkg::CMD_TICK;
			ptr_q       <= '0;
			tgt_q       <= '0;
			resume_q    <= '0;
			run_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			live_q      <= '0;
			c_q         <= '0;
			start_q     <= '0;
			i_q         <= '0;
			cand_q      <= '0;
			nx_q        <= '0;
			ns_q        <= '0;
			next_id_q   <= ID_BITS'(1);
			nid_q       <= '0;
			status_q    <= rrts_pkg::STAT_OK;
			sw_q        <= 1'b0;
			found_q     <= 1'b0;
			fault_q     <= 1'b0;
			ticks_q     <= '0;
			slice_q     <= '0;
			preempt_q   <= 1'b0;
			slice_len_q <= rrts_pkg::SLICE_RESET;
		end else begin
			case (cmd.op)
				rrts_pkg::OP_LOAD: begin
					cmd_q    <= cmd_in;
					ptr_q    <= ptr_in;
					tgt_q    <= tgt_in;
					resume_q <= ptr_in;
					status_q <= rrts_pkg::STAT_OK;
					sw_q     <= 1'b0;
					ns_q     <= '0;
					nid_q    <= '0;
					found_q  <= 1'b0;
				end
				rrts_pkg::OP_DECODE: begin
					status_q <= dec_stat;
					if (cmd_q == rrts_pkg::CMD_TICK && dec_stat == rrts_pkg::STAT_OK) begin
						ticks_q <= ticks_q + 1'b1;
						if (preempt_q) begin
							slice_q <= (route == rrts_pkg::R_FIND) ? '0 : slice_inc;
						end
					end
					c_q     <= (route == rrts_pkg::R_EXIT) ? head_q : rd_lk;
					start_q <= rd_lk;
					nx_q    <= rd_lk;
					i_q     <= (route == rrts_pkg::R_CREATE) ? SW'(1) : '0;
				end
				rrts_pkg::OP_FIND: begin
					if (stat.hit) begin
						cand_q  <= c_q;
						found_q <= 1'b1;
					end else if (stat.last) begin
						if (is_block) begin
							status_q <= rrts_pkg::STAT_REFUSED;
						end
					end else begin
						c_q <= rd_lk;
						i_q <= i_q + 1'b1;
					end
				end
				rrts_pkg::OP_APPLY1: begin
					// nothing runnable and the current thread cannot go on
					if (!found_q && rd_st != rrts_pkg::SS_RUN) begin
						fault_q <= 1'b1;
					end
				end
				rrts_pkg::OP_APPLY2: begin
					run_q <= cand_q;
					sw_q  <= (cand_q != run_q);
				end
				rrts_pkg::OP_APPLY3: begin
					resume_q <= ctx_rdata;
				end
				rrts_pkg::OP_FREE_SCAN: begin
					if (stat.hit) begin
						cand_q <= i_q;
					end else if (stat.last) begin
						status_q <= rrts_pkg::STAT_NO_FREE;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				rrts_pkg::OP_CREATE1: begin
					nid_q     <= next_id_q;
					next_id_q <= next_id_q + 1'b1;
				end
				rrts_pkg::OP_CREATE2: begin
					tail_q <= cand_q;
					live_q <= live_q + 1'b1;
					ns_q   <= cand_q;
				end
				rrts_pkg::OP_EX_SEARCH: begin
					if (stat.hit) begin
						found_q <= 1'b1;
					end else if (!stat.last) begin
						c_q <= rd_lk;
						i_q <= i_q + 1'b1;
					end
				end
				rrts_pkg::OP_EX_FIX: begin
					live_q  <= live_q - 1'b1;
					found_q <= 1'b0;
					if (found_q) begin
						if (head_q == run_q) begin
							head_q <= nx_q;
						end
						if (tail_q == run_q) begin
							tail_q <= c_q;
						end
					end
					c_q     <= head_q;
					start_q <= head_q;
					i_q     <= '0;
				end
				rrts_pkg::OP_EX_LINK: begin
					c_q     <= head_q;
					start_q <= head_q;
					i_q     <= '0;
				end
				default: begin
					found_q <= found_q;
				end
			endcase
			if (cfg.we) begin
				if (cfg.sel == rrts_pkg::REG_PREEMPT) begin
					preempt_q <= cfg.data[0];
					slice_q   <= '0;
				end else begin
					slice_len_q <= cfg.data;
				end
			end
		end
	end

	rrts_ram #(
		.WIDTH(CONTEXT_BITS),
		.DEPTH(MAX_THREADS)
	) u_ctx_ram (
		.clk   (clk),
		.we    (ctx_we),
		.waddr (ctx_wa),
		.wdata (ctx_wd),
		.raddr (cand_q),
		.rdata (ctx_rdata)
	);

	rrts_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(MAX_THREADS)
	) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (cand_q),
		.wdata (next_id_q),
		.raddr (run_q),
		.rdata (id_rdata)
	);

	assign status       = status_q;
	assign switched     = sw_q;
	assign current_slot = run_q;
	// the boot slot is never written and keeps id zero
	assign current_id   = (run_q == '0) ? '0 : id_rdata;
	assign resume_ptr   = resume_q;
	assign new_slot     = ns_q;
	assign new_id       = nid_q;
	assign live_count   = live_q;
	assign tick_count   = ticks_q;
	assign fault        = fault_q;

endmodule
`default_nettype wire

### rtl/core/round_robin_thread_scheduler_core.sv
// Channel   Ports                                              Handshake
// command   cmd, context_ptr, target_slot                      start && !busy
// result    status, switched, current_slot, current_id,        done, one cycle
//           resume_ptr, new_slot, new_id, live_count,
//           tick_count, fault
// config    psel, penable, pwrite, paddr, pwdata, prdata        APB, pready tied high
//
// The shortest commands (refused, null, wake, plain tick) go from decode straight
// to finish; the longest is exit: a walk to the predecessor, then a walk for the
// next ready slot. Each walk reads one slot of the thread table a cycle.
// Reset leaves slot 0 running; no clearing pass is needed.
// done pulses once per command; results are not held back by the receiver.
`default_nettype none
module round_robin_thread_scheduler_core #(
	parameter int MAX_THREADS  = 16,
	parameter int CONTEXT_BITS = 48,
	parameter int ID_BITS      = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    start,
	output logic                                         busy,
	input  wire logic [rrts_pkg::CMD_BITS-1:0]           cmd,
	input  wire logic [CONTEXT_BITS-1:0]                 context_ptr,
	input  wire logic [$clog2(MAX_THREADS)-1:0]          target_slot,
	output logic                                         done,
	output logic      [rrts_pkg::STAT_BITS-1:0]          status,
	output logic                                         switched,
	output logic      [$clog2(MAX_THREADS)-1:0]          current_slot,
	output logic      [ID_BITS-1:0]                      current_id,
	output logic      [CONTEXT_BITS-1:0]                 resume_ptr,
	output logic      [$clog2(MAX_THREADS)-1:0]          new_slot,
	output logic      [ID_BITS-1:0]                      new_id,
	output logic      [$clog2(MAX_THREADS)-1:0]          live_count,
	output logic      [rrts_pkg::TICK_BITS-1:0]          tick_count,
	output logic                                         fault,
	input  wire logic                                    psel,
	input  wire logic                                    penable,
	input  wire logic                                    pwrite,
	input  wire logic [2:0]                              paddr,
	input  wire logic [31:0]                             pwdata,
	output logic      [31:0]                             prdata,
	output logic                                         pready
);

	rrts_pkg::dp_cmd_t  dp_cmd;
	rrts_pkg::dp_stat_t dp_stat;
	rrts_pkg::cfg_wr_t  cfg;
	logic                            preempt;
	logic [rrts_pkg::SLICE_BITS-1:0] slice_len;

	assign pready   = 1'b1;
	assign cfg.we   = psel && penable && pwrite;
	assign cfg.sel  = paddr[2];
	assign cfg.data = pwdata[rrts_pkg::SLICE_BITS-1:0];

	assign prdata = (paddr[2] == rrts_pkg::REG_SLICE) ?
		{{(32 - rrts_pkg::SLICE_BITS){1'b0}}, slice_len} : {31'b0, preempt};

	rrts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.cmd    (dp_cmd),
		.busy   (busy),
		.done   (done)
	);

	rrts_dp #(
		.MAX_THREADS  (MAX_THREADS),
		.CONTEXT_BITS (CONTEXT_BITS),
		.ID_BITS      (ID_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.cfg          (cfg),
		.cmd_in       (cmd),
		.ptr_in       (context_ptr),
		.tgt_in       (target_slot),
		.status       (status),
		.switched     (switched),
		.current_slot (current_slot),
		.current_id   (current_id),
		.resume_ptr   (resume_ptr),
		.new_slot     (new_slot),
		.new_id       (new_id),
		.live_count   (live_count),
		.tick_count   (tick_count),
		.fault        (fault),
		.preempt_q    (preempt),
		.slice_len_q  (slice_len)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("result strobe not followed by idle");

	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && switched |-> status == rrts_pkg::STAT_OK)
		else $error("switch reported on a failed command");

	a_new_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != rrts_pkg::STAT_OK |-> new_slot == '0 && new_id == '0)
		else $error("new slot reported on a failed command");

endmodule
`default_nettype wire
